### rtl/ppmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppmd_pkg
// Shared widths, constants and the result record of the PPM pulse train
// decoder.
// ----------------------------------------------------------------------------
package ppmd_pkg;

    // field widths
    localparam int WIDTH_W    = 16;
    localparam int SLOT_IDX_W = 4;

    // saturation limit of the pulse width counter
    localparam logic [WIDTH_W-1:0] WIDTH_MAX = {WIDTH_W{1'b1}};

    // sync threshold after reset
    localparam logic [WIDTH_W-1:0] SYNC_THRESHOLD_RST = 16'd3000;

    // one decoded pulse
    typedef struct packed {
        logic [WIDTH_W-1:0]    pulse_width;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic                  slot_written;
        logic                  is_sync;
        logic                  frame_complete;
        logic                  slot_overflow;
    } pulse_result_t;

endpackage

### rtl/ppm_pulse_train_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_pulse_train_decoder_top
// Measures high pulses on a sampled PPM line and sorts them into frame slots.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, line_level) carries one line sample
//   per timebase tick. Output channel (out_valid / out_stall) carries one
//   item per completed high pulse: its width, the slot it went to, and the
//   sync, frame complete and overflow flags. Samples that end no pulse give
//   no output item.
//   A sample is captured in the input register, decoded from there, and
//   its item is written into the result register, where out_valid rises.
//   Throughput: one sample per cycle while in_stall is low; the input and
//   result registers form a two-stage pipe, the decode step a single pass.
//   Stall: while a result waits in the output register, samples that make no
//   result still flow; a sample that would end a pulse waits in the input
//   register and in_stall goes high until the receiver takes the result.
//   Reset: all control state clears, sync_threshold returns to 3000 and no
//   frame is open. The config port (cfg_valid / cfg_ready, cfg_data) is
//   always ready and should be written only while the block is idle.
// ----------------------------------------------------------------------------
module ppm_pulse_train_decoder_top #(
    parameter int SLOTS = 9
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // config write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ppmd_pkg::WIDTH_W-1:0]    cfg_data,
    // sample channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            line_level,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ppmd_pkg::WIDTH_W-1:0]    pulse_width,
    output logic [ppmd_pkg::SLOT_IDX_W-1:0] slot_index,
    output logic                            slot_written,
    output logic                            is_sync,
    output logic                            frame_complete,
    output logic                            slot_overflow
);

    localparam int SC_W = $clog2(SLOTS + 1);
    localparam logic [SC_W-1:0] SLOTS_LIM = SC_W'(SLOTS);

    // config register
    logic [ppmd_pkg::WIDTH_W-1:0] sync_threshold_reg;

    // input stage
    logic s1_valid_reg;
    logic s1_level_reg;

    // decoder state
    logic                         previous_level_reg, previous_level_next;
    logic                         measuring_reg, measuring_next;
    logic [ppmd_pkg::WIDTH_W-1:0] width_counter_reg, width_counter_next;
    logic                         in_frame_reg, in_frame_next;
    logic [SC_W-1:0]              slot_count_reg, slot_count_next;

    // output stage
    logic                    out_valid_reg;
    ppmd_pkg::pulse_result_t out_reg, out_next;

    logic produces;
    logic out_free;
    logic advance;
    logic in_take;
    logic sync_hit;

    assign cfg_ready = 1'b1;

    // config write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_threshold_reg <= ppmd_pkg::SYNC_THRESHOLD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            sync_threshold_reg <= cfg_data;
        end
    end

    // pipe control
    assign produces = !s1_level_reg && previous_level_reg && measuring_reg;
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && (!produces || out_free);
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_level_reg <= line_level;
        end
    end

    // decode step
    assign sync_hit = width_counter_reg > sync_threshold_reg;

    always_comb
    begin
        previous_level_next = s1_level_reg;
        measuring_next      = measuring_reg;
        width_counter_next  = width_counter_reg;
        in_frame_next       = in_frame_reg;
        slot_count_next     = slot_count_reg;

        out_next.pulse_width    = width_counter_reg;
        out_next.slot_index     = '0;
        out_next.slot_written   = 1'b0;
        out_next.is_sync        = sync_hit;
        out_next.frame_complete = 1'b0;
        out_next.slot_overflow  = 1'b0;

        if (s1_level_reg)
        begin
            // rising edge starts a count, high samples extend it
            if (!previous_level_reg)
            begin
                measuring_next     = 1'b1;
                width_counter_next = {{(ppmd_pkg::WIDTH_W-1){1'b0}}, 1'b1};
            end
            else if (measuring_reg && width_counter_reg != ppmd_pkg::WIDTH_MAX)
            begin
                width_counter_next = width_counter_reg + 1'b1;
            end
        end
        else if (produces)
        begin
            measuring_next = 1'b0;

            // slot fill inside a frame
            if (in_frame_reg)
            begin
                if (slot_count_reg < SLOTS_LIM)
                begin
                    out_next.slot_index = ppmd_pkg::SLOT_IDX_W'(slot_count_reg)
                                        + 1'b1;
                    out_next.slot_written = 1'b1;
                    slot_count_next       = slot_count_reg + 1'b1;
                end
                else
                begin
                    out_next.slot_overflow = 1'b1;
                end
            end

            // sync opens or closes a frame
            if (sync_hit)
            begin
                if (in_frame_reg)
                begin
                    in_frame_next           = 1'b0;
                    slot_count_next         = '0;
                    out_next.frame_complete = 1'b1;
                end
                else
                begin
                    in_frame_next = 1'b1;
                end
            end
        end
    end

    // decoder state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_level_reg <= 1'b0;
            measuring_reg      <= 1'b0;
            width_counter_reg  <= '0;
            in_frame_reg       <= 1'b0;
            slot_count_reg     <= '0;
        end
        else if (advance)
        begin
            previous_level_reg <= previous_level_next;
            measuring_reg      <= measuring_next;
            width_counter_reg  <= width_counter_next;
            in_frame_reg       <= in_frame_next;
            slot_count_reg     <= slot_count_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && produces)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && produces)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign pulse_width    = out_reg.pulse_width;
    assign slot_index     = out_reg.slot_index;
    assign slot_written   = out_reg.slot_written;
    assign is_sync        = out_reg.is_sync;
    assign frame_complete = out_reg.frame_complete;
    assign slot_overflow  = out_reg.slot_overflow;

endmodule
